FILE: rtl/core/msc_pkg.sv
// Shared types and constants for the minimum square sum counter.
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

   localparam int unsigned TARGET_W = 16;
   localparam int unsigned COUNT_W  = 3;

   // Starting value of every table entry before the minimum search.
   localparam logic [COUNT_W-1:0] START_BEST = 3'd5;
   // Count for an exact square, and for entry one.
   localparam logic [COUNT_W-1:0] ONE_SQUARE = 3'd1;
   // Largest count that a finished entry can hold.
   localparam logic [COUNT_W-1:0] MAX_COUNT  = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;         // capture a new request
      logic write_one;    // write entry one and open entry two
      logic scan_step;    // test one square candidate of the current entry
      logic store_entry;  // write the current entry and open the next one
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;       // request target is zero
      logic n_one;        // request target is one
      logic scan_done;    // all squares up to the current entry have been tried
      logic entry_last;   // the current entry is the requested one
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/msc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module msc_ram #(
   parameter int unsigned WIDTH = 3,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/msc_ctrl.sv
// Sequencing state machine for the minimum square sum counter.
`timescale 1ns / 1ps
`default_nettype none

module msc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire msc_pkg::dp_status_type status,
   output msc_pkg::ctrl_cmd_type       cmd,
   output logic                        busy,
   output logic                        rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_STORE,
      ST_REPLY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.n_zero) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_REPLY;
            end else begin
               cmd.write_one = 1'b1;
               if (status.n_one) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_REPLY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_STORE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_STORE: begin
            cmd.store_entry = 1'b1;
            if (status.entry_last) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_REPLY;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_REPLY: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> busy_ff)
      else $error("response strobe outside a busy period");

   a_busy_ends_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy_ff)) |-> $past(rsp_valid_ff))
      else $error("busy dropped without a response");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && !rsp_valid_ff))
      else $error("accepted request did not raise busy");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/msc_datapath.sv
// Table builder datapath: square candidate walk, minimum search and answer capture.
`timescale 1ns / 1ps
`default_nettype none

module msc_datapath #(
   parameter int unsigned MAX_TARGET = 65535,
   localparam int unsigned ADDR_W    = $clog2(MAX_TARGET + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire msc_pkg::ctrl_cmd_type         cmd,
   output msc_pkg::dp_status_type             status,
   input  wire logic [msc_pkg::TARGET_W-1:0]  req_target,
   output logic      [msc_pkg::COUNT_W-1:0]   answer,
   output logic                               wr_en,
   output logic      [ADDR_W-1:0]             wr_addr,
   output logic      [msc_pkg::COUNT_W-1:0]   wr_data,
   output logic                               rd_en,
   output logic      [ADDR_W-1:0]             rd_addr,
   input  wire logic [msc_pkg::COUNT_W-1:0]   rd_data
);

   localparam int unsigned CMP_W = (ADDR_W > msc_pkg::TARGET_W) ? ADDR_W : msc_pkg::TARGET_W;
   localparam int unsigned SQ_W  = ADDR_W + 1;

   logic [ADDR_W-1:0]           n_ff, i_ff;
   logic [SQ_W-1:0]             sq_ff, odd_ff;
   logic [msc_pkg::COUNT_W-1:0] best_ff, answer_ff;
   logic                        exact_ff, rd_pend_ff;

   logic [CMP_W-1:0]            target_wide;
   logic [ADDR_W-1:0]           target_sat;
   logic [SQ_W-1:0]             i_wide;
   logic                        sq_below, sq_equal;
   logic [msc_pkg::COUNT_W:0]   cand_sum;
   logic [msc_pkg::COUNT_W-1:0] entry_value;
   logic                        open_entry;

   assign target_wide = CMP_W'(req_target);
   assign target_sat  = (target_wide > CMP_W'(MAX_TARGET)) ? ADDR_W'(MAX_TARGET)
                                                           : ADDR_W'(target_wide);

   assign i_wide   = {1'b0, i_ff};
   assign sq_below = sq_ff < i_wide;
   assign sq_equal = sq_ff == i_wide;

   // Entry j*j always holds one, so each candidate costs one table read.
   assign cand_sum    = {1'b0, rd_data} + (msc_pkg::COUNT_W + 1)'(1);
   assign entry_value = exact_ff ? msc_pkg::ONE_SQUARE : best_ff;
   assign open_entry  = cmd.write_one || cmd.store_entry;

   assign status.n_zero     = n_ff == '0;
   assign status.n_one      = n_ff == ADDR_W'(1);
   assign status.scan_done  = !sq_below && !sq_equal;
   assign status.entry_last = i_ff == n_ff;

   assign wr_en   = open_entry;
   assign wr_addr = cmd.write_one ? ADDR_W'(1) : i_ff;
   assign wr_data = cmd.write_one ? msc_pkg::ONE_SQUARE : entry_value;

   assign rd_en   = cmd.scan_step && sq_below;
   assign rd_addr = i_ff - sq_ff[ADDR_W-1:0];

   assign answer = answer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff      <= target_sat;
         answer_ff <= '0;
      end
      if (cmd.write_one && status.n_one) begin
         answer_ff <= msc_pkg::ONE_SQUARE;
      end
      if (cmd.store_entry && status.entry_last) begin
         answer_ff <= entry_value;
      end

      if (rd_pend_ff && (cand_sum < {1'b0, best_ff})) begin
         best_ff <= cand_sum[msc_pkg::COUNT_W-1:0];
      end

      if (cmd.scan_step) begin
         if (sq_equal) begin
            exact_ff <= 1'b1;
         end
         sq_ff  <= sq_ff + odd_ff;
         odd_ff <= odd_ff + SQ_W'(2);
      end

      if (open_entry) begin
         i_ff     <= cmd.write_one ? ADDR_W'(2) : i_ff + ADDR_W'(1);
         sq_ff    <= SQ_W'(1);
         odd_ff   <= SQ_W'(3);
         best_ff  <= msc_pkg::START_BEST;
         exact_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_entry_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_data >= msc_pkg::ONE_SQUARE && wr_data <= msc_pkg::MAX_COUNT))
      else $error("table entry written outside one to four");

   a_no_open_during_read: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !open_entry)
      else $error("entry closed while a table read was still in flight");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/min_square_sum_count.sv
// Top level of the minimum square sum counter: controller, datapath and scratch table.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request is accepted at a rising clock edge where start is high and busy is low;
// req_target must be valid at that edge. Targets above MAX_TARGET are saturated to it.
// busy rises at the accepting edge and stays high until the reply has been taken.
// For each request the block rebuilds its scratch table from entry one up to the
// target, then pulses rsp_valid for exactly one cycle with rsp_square_count, the
// fewest perfect squares (1 to 4) summing to the target; a target of zero answers 0.
// The receiver cannot stall: the reply is taken at the edge that ends its cycle.
// Each entry takes one table read per square candidate below it on the single read
// port, then one write of the entry.
// For a target of zero or one, rsp_valid rises at the first edge after acceptance.
// busy drops at the edge that takes the reply, and a new request may be accepted
// from the edge after that.
// Reset is synchronous and active high; it returns the controller to idle and drops
// busy and rsp_valid. The table needs no clearing: every entry is written before a
// request reads it.

module min_square_sum_count #(
   parameter int unsigned MAX_TARGET = 65535
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [msc_pkg::TARGET_W-1:0] req_target,
   output logic                              rsp_valid,
   output logic      [msc_pkg::COUNT_W-1:0]  rsp_square_count
);

   localparam int unsigned ADDR_W = $clog2(MAX_TARGET + 1);

   msc_pkg::ctrl_cmd_type       cmd;
   msc_pkg::dp_status_type      status;
   logic                        wr_en, rd_en;
   logic [ADDR_W-1:0]           wr_addr, rd_addr;
   logic [msc_pkg::COUNT_W-1:0] wr_data, rd_data;

   // The controller walks each request through setup, the per-entry candidate
   // scan and the entry write, and issues the reply strobe.
   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the request, the current entry, the running square and
   // odd step, and the running minimum; it drives both table ports.
   msc_datapath #(
      .MAX_TARGET (MAX_TARGET)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_target (req_target),
      .answer     (rsp_square_count),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // Scratch table of best counts, one entry per value up to MAX_TARGET.
   msc_ram #(
      .WIDTH (msc_pkg::COUNT_W),
      .DEPTH (MAX_TARGET + 1)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef SYNTHESIS
   a_reply_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_square_count <= msc_pkg::MAX_COUNT))
      else $error("reply count above four");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_min_square_sum_count.sv
// Self-checking testbench for the minimum square sum counter.
`timescale 1ns / 1ps

module tb_min_square_sum_count;

   // The block is built with its default table size, so that every 16-bit target fits.
   localparam int unsigned MAX_TARGET   = 65535;
   localparam int unsigned CLOCK_PERIOD = 20;
   // The limit allows for the request for the largest target and for the random
   // requests at their slowest, so this is several times the slowest correct run.
   localparam longint unsigned CYCLE_LIMIT = 100_000_000;
   // Once the last reply has arrived, a short quiet spell shows up any stray reply.
   localparam int unsigned DRAIN_CYCLES = 20;
   // Beyond this many mismatch lines, failures are still counted but not printed.
   localparam int unsigned PRINT_CAP    = 20;

   // Each accepted request leaves one of these behind until its reply arrives.
   typedef struct {
      logic [msc_pkg::TARGET_W-1:0] target;
      logic [msc_pkg::COUNT_W-1:0]  count;
   } square_reply_type;

   // Every input is known from time zero, and reset is high from the start.
   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         start      = 1'b0;
   logic [msc_pkg::TARGET_W-1:0] req_target = '0;
   logic                         busy;
   logic                         rsp_valid;
   logic [msc_pkg::COUNT_W-1:0]  rsp_square_count;

   square_reply_type    pending_replies[$];
   int unsigned         mismatch_count = 0;
   longint unsigned     cycle_count    = 0;
   int unsigned         burst_left     = 0;

   // The scratch table of the predictor. It is two-state, so it starts out all zero.
   byte unsigned        square_table [0:MAX_TARGET];

   min_square_sum_count #(
      .MAX_TARGET(MAX_TARGET)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_square_count(rsp_square_count)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // The predictor rebuilds its table from the bottom for every request, exactly as
   // the block does. Entry i starts at five and keeps the best split into a square
   // and a remainder; an exact square is forced to one. A target of zero is not a
   // proper request and answers zero, the sum of no squares at all.
   function automatic logic [msc_pkg::COUNT_W-1:0] fewest_squares(input int unsigned target);
      int unsigned n;
      int unsigned best;
      int unsigned split_sum;
      int unsigned root;
      bit          exact;
      n = (target > MAX_TARGET) ? MAX_TARGET : target;
      square_table[0] = 0;
      if (n == 0) begin
         return '0;
      end
      square_table[1] = 1;
      for (int unsigned i = 2; i <= n; i++) begin
         best  = 5;
         exact = 1'b0;
         for (root = 1; root * root <= i; root++) begin
            // When the square is the entry itself, this reads a stale value; the
            // forcing to one below makes that harmless.
            split_sum = square_table[root * root] + square_table[i - root * root];
            if (split_sum < best) begin
               best = split_sum;
            end
            if (root * root == i) begin
               exact = 1'b1;
            end
         end
         if (exact) begin
            best = 1;
         end
         square_table[i] = byte'(best & 7);
      end
      return msc_pkg::COUNT_W'(square_table[n]);
   endfunction

   // Prints one line per failure, up to a cap, and counts every one.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("ERROR at %0t ns: %s", $realtime, what);
      end
   endtask

   // Reply checker. A reply is on the ports for exactly one cycle and is taken at the
   // edge that ends that cycle; the values seen here are those from before the edge.
   always @(posedge clock) begin
      square_reply_type oldest;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply %0d with no request outstanding",
                                      rsp_square_count));
         end else begin
            oldest = pending_replies.pop_front();
            if (rsp_square_count !== oldest.count) begin
               report_mismatch($sformatf("target %0d: square_count %0d, expected %0d",
                                         oldest.target, rsp_square_count, oldest.count));
            end
         end
      end else if (!reset && rsp_valid !== 1'b0) begin
         report_mismatch("rsp_valid is unknown");
      end
   end

   // Watchdog: a hung block must not keep the simulation running for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, pending_replies.size());
         $display("min_square_sum_count: mismatch");
         $finish;
      end
   end

   // The sender works in bursts of random length. Within a burst start stays high, so
   // a new request waits only for busy to drop; between bursts start falls for a
   // random gap, which lands on whatever phase the block happens to be in.
   task automatic pace_sender();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
         burst_left = $urandom_range(8, 0);
      end
   endtask

   // Offers one request and waits for the handshake. It is entered just after a rising
   // edge, and the request is accepted at the first edge where busy is seen low.
   task automatic send_request(input logic [msc_pkg::TARGET_W-1:0] target);
      square_reply_type expected;
      start      <= 1'b1;
      req_target <= target;
      do @(posedge clock); while (busy !== 1'b0);
      expected.target = target;
      expected.count  = fewest_squares(target);
      pending_replies.push_back(expected);
      pace_sender();
   endtask

   // The smallest targets, including zero, which is no proper request.
   task automatic test_smallest_targets();
      for (int unsigned t = 0; t <= 4; t++) begin
         send_request(msc_pkg::TARGET_W'(t));
      end
   endtask

   // Targets whose answer is one, two, three and four, among them multiples of four
   // that need four squares.
   task automatic test_answer_classes();
      int unsigned targets[9] = '{7, 12, 13, 25, 28, 31, 48, 100, 112};
      foreach (targets[k]) begin
         send_request(msc_pkg::TARGET_W'(targets[k]));
      end
   endtask

   // Single set bits across the lower part of the target; the upper bits are taken by
   // the largest target, as lower powers keep the run short.
   task automatic test_single_bits();
      for (int unsigned b = 4; b <= 11; b++) begin
         send_request(msc_pkg::TARGET_W'(1 << b));
      end
   endtask

   // All target bits set: the full table is built once.
   task automatic test_largest_target();
      send_request(msc_pkg::TARGET_W'(MAX_TARGET));
   endtask

   // Random requests. Most targets are small, since the cost grows as n to the power
   // one and a half; a tenth reach up to 4095, and exact squares and numbers that need
   // four squares are drawn on purpose, as plain random values rarely give them.
   task automatic test_random_targets(input int unsigned count);
      int unsigned target;
      int unsigned shift;
      int unsigned odd_part;
      repeat (count) begin
         case ($urandom_range(9, 0))
            0, 1: begin
               odd_part = $urandom_range(63, 1);
               target   = odd_part * odd_part;
            end
            2: begin
               // Of the form 4^a * (8b + 7), which no three squares can reach.
               shift    = $urandom_range(4, 0);
               odd_part = $urandom_range(((4095 >> (2 * shift)) - 7) / 8, 0);
               target   = (8 * odd_part + 7) << (2 * shift);
            end
            3: begin
               target = $urandom_range(4095, 1);
            end
            default: begin
               target = $urandom_range(400, 1);
            end
         endcase
         send_request(msc_pkg::TARGET_W'(target));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_smallest_targets();
      test_answer_classes();
      test_single_bits();
      test_random_targets(80);
      // The largest target runs last, so that the quick checks report first.
      test_largest_target();

      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("min_square_sum_count: match");
      end else begin
         $display("min_square_sum_count: mismatch");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/msc_pkg.sv
rtl/core/msc_ram.sv
rtl/core/msc_ctrl.sv
rtl/core/msc_datapath.sv
rtl/core/min_square_sum_count.sv
bench/tb_min_square_sum_count.sv
